// ----- hw/rtl/slr_pkg.sv -----
// shared types and constants for the stereo linear resampler
package slr_pkg;

    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int PHASE_FRAC_BITS_DEF = 16;

    // cap on results per input frame
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // apb register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_SEL_RATE = 1'b0;
    localparam logic REG_SEL_MODE = 1'b1;

    localparam logic MODE_STEREO = 1'b0;
    localparam logic MODE_MONO   = 1'b1;

    typedef struct packed {
        logic load;    // take a new frame, form the differences
        logic mul;     // register the phase products
        logic emit;    // form a result and step the phase
        logic finish;  // wrap the phase and keep the frame
    } t_cmd;

    typedef struct packed {
        logic go;      // phase still at or below one and cap not reached
        logic last;    // the result being formed ends this frame's run
    } t_sts;

endpackage

// ----- hw/rtl/slr_ctrl.sv -----
// control state machine for the stereo linear resampler
module slr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  slr_pkg::t_sts i_sts,
    output slr_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   slot_free;

    assign slot_free     = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.go) begin
                    n_state = ST_MUL;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
        if (o_cmd.emit) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ----- hw/rtl/slr_datapath.sv -----
// phase accumulator, interpolation multipliers and output register
module slr_datapath #(
    parameter int SAMPLE_BITS     = slr_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  slr_pkg::t_cmd                i_cmd,
    output slr_pkg::t_sts                o_sts,
    input  logic [PHASE_FRAC_BITS+3:0]   i_rate,
    input  logic                         i_mode,
    input  logic [SAMPLE_BITS-1:0]       i_in_left,
    input  logic [SAMPLE_BITS-1:0]       i_in_right,
    output logic [SAMPLE_BITS-1:0]       o_out_left,
    output logic [SAMPLE_BITS-1:0]       o_out_right,
    output logic                         o_last
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = PHASE_FRAC_BITS;
    localparam int PW  = F + 4;
    localparam int WPW = PW + 1;
    localparam int DW  = S + 1;
    localparam int MW  = F + 2;
    localparam int PRW = DW + MW;
    localparam int CW  = slr_pkg::CNT_W;
    localparam logic [WPW-1:0] PH_ONE   = WPW'(1) << F;
    localparam logic [CW-1:0]  CNT_MAX  = CW'(slr_pkg::MAX_RESULTS);
    localparam logic [CW-1:0]  CNT_LAST = CW'(slr_pkg::MAX_RESULTS - 1);

    logic [S-1:0]          r_prev_l, r_prev_r;
    logic [S-1:0]          r_x_l, r_x_r;
    logic signed [DW-1:0]  r_diff_l, r_diff_r;
    logic signed [PRW-1:0] r_prod_l, r_prod_r;
    logic [WPW-1:0]        r_ph;
    logic [CW-1:0]         r_cnt;
    logic [S-1:0]          r_out_l, r_out_r;
    logic                  r_last;

    logic [WPW-1:0]        ph_next;
    logic [WPW-1:0]        ph_end;
    logic [WPW-1:0]        ph_fin;
    logic signed [MW-1:0]  ph_mul;
    logic signed [PRW-1:0] step_l, step_r;
    logic [DW-1:0]         sum_l, sum_r;
    logic [S-1:0]          int_l, int_r;
    logic [DW-1:0]         mix;
    logic [S-1:0]          res_l, res_r;

    // working phase never exceeds one plus the rate, so one spare bit is enough
    assign ph_next    = r_ph + WPW'(i_rate);
    assign o_sts.go   = (r_ph <= PH_ONE) && (r_cnt < CNT_MAX);
    assign o_sts.last = (ph_next > PH_ONE) || (r_cnt == CNT_LAST);

    assign ph_end = i_cmd.emit ? ph_next : r_ph;
    assign ph_fin = (ph_end >= PH_ONE) ? (ph_end - PH_ONE) : '0;

    // products are only taken while the phase is at most one
    assign ph_mul = $signed({1'b0, r_ph[F:0]});

    // arithmetic shift of the product floors toward minus infinity
    assign step_l = r_prod_l >>> F;
    assign step_r = r_prod_r >>> F;
    assign sum_l  = {r_prev_l[S-1], r_prev_l} + step_l[DW-1:0];
    assign sum_r  = {r_prev_r[S-1], r_prev_r} + step_r[DW-1:0];
    assign int_l  = sum_l[S-1:0];
    assign int_r  = sum_r[S-1:0];
    assign mix    = {int_l[S-1], int_l} + {int_r[S-1], int_r};

    always_comb begin
        res_l = int_l;
        res_r = int_r;
        if (i_mode == slr_pkg::MODE_MONO) begin
            res_l = mix[S:1];
            res_r = mix[S:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_ph     <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.emit) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.finish) begin
                r_ph     <= {1'b0, ph_fin[PW-1:0]};
                r_prev_l <= r_x_l;
                r_prev_r <= r_x_r;
            end else if (i_cmd.emit) begin
                r_ph <= ph_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x_l    <= i_in_left;
            r_x_r    <= i_in_right;
            r_diff_l <= $signed({i_in_left[S-1], i_in_left} - {r_prev_l[S-1], r_prev_l});
            r_diff_r <= $signed({i_in_right[S-1], i_in_right} - {r_prev_r[S-1], r_prev_r});
        end
        if (i_cmd.mul) begin
            r_prod_l <= r_diff_l * ph_mul;
            r_prod_r <= r_diff_r * ph_mul;
        end
        if (i_cmd.emit) begin
            r_out_l <= res_l;
            r_out_r <= res_r;
            r_last  <= o_sts.last;
        end
    end

    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;
    assign o_last      = r_last;

endmodule

// ----- hw/rtl/stereo_linear_resampler_unit.sv -----
// top level of the stereo linear resampler: streams, apb registers, assertions

// Linear-interpolation sample rate converter for stereo frames. Each input
// beat carries one frame and yields zero to nine output beats, the final one
// of a frame's run marked with m_axis_tlast. A frame is first accepted, then
// its phase is tested, then each result takes a multiply step and an add step
// through the single pair of multipliers, and the add step waits while the
// output register still holds a beat not taken by m_axis_tready. A new
// frame is accepted only once the previous frame's results have all been
// formed. Registers: rate at 0x0 (unsigned, 4 integer and PHASE_FRAC_BITS
// fraction bits, reset 1.0), output mode at 0x4 (bit 0: 1 for the mono
// average on both channels). Write registers only while the block is idle.
module stereo_linear_resampler_unit #(
    parameter int SAMPLE_BITS     = slr_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // in_left [SAMPLE_BITS-1:0], in_right above it, zero padded to bytes
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // out_left [SAMPLE_BITS-1:0], out_right above it, zero padded to bytes
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                         m_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slr_pkg::PADDR_W-1:0]  paddr,
    input  logic [slr_pkg::PDATA_W-1:0]  pwdata,
    output logic [slr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int S  = SAMPLE_BITS;
    localparam int F  = PHASE_FRAC_BITS;
    localparam int PW = F + 4;
    localparam int TW = ((2*SAMPLE_BITS+7)/8)*8;
    localparam logic [PW-1:0] RATE_RST = PW'(1) << F;

    logic [PW-1:0]  r_rate;
    logic           r_mode;
    logic           cfg_wr;
    slr_pkg::t_cmd  cmd;
    slr_pkg::t_sts  sts;
    logic [S-1:0]   out_l, out_r;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RST;
            r_mode <= slr_pkg::MODE_STEREO;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                slr_pkg::REG_SEL_RATE: r_rate <= pwdata[PW-1:0];
                slr_pkg::REG_SEL_MODE: r_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            slr_pkg::REG_SEL_RATE: prdata = slr_pkg::PDATA_W'(r_rate);
            slr_pkg::REG_SEL_MODE: prdata = slr_pkg::PDATA_W'(r_mode);
            default:               prdata = '0;
        endcase
    end

    slr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    slr_datapath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_rate      (r_rate),
        .i_mode      (r_mode),
        .i_in_left   (s_axis_tdata[S-1:0]),
        .i_in_right  (s_axis_tdata[2*S-1:S]),
        .o_out_left  (out_l),
        .o_out_right (out_r),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = TW'({out_r, out_l});

    // a result is never written over one still waiting on the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten while a beat was pending");

    // results only while the phase permits and below the cap
    a_emit_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.go)
        else $error("result formed with phase above one or cap reached");

    // an accepted frame is tested before any result is formed
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!cmd.emit && !cmd.mul && !s_axis_tready))
        else $error("frame not followed by the phase test");

    // load, multiply and emit commands never overlap
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.emit}))
        else $error("overlapping datapath commands");

endmodule

// ----- test/stereo_linear_resampler_unit_tb.sv -----
// self-checking testbench for the stereo linear resampler: streams, apb set-up, scoreboard
module stereo_linear_resampler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int PH_W       = FRAC_W + 4;
    localparam int DATA_W     = ((2 * SMP_W + 7) / 8) * 8;
    localparam longint PH_ONE = 64'd1 << FRAC_W;
    // time to let a frame's run of up to nine results finish inside the block
    localparam int SETTLE_CYC = 24;
    localparam int HOLD_CYC   = 300;
    localparam int QUIET_MAX  = 2000;
    localparam int RAND_PHASES     = 8;
    localparam int FRAMES_PER_PH   = 58;

    localparam logic [slr_pkg::PADDR_W-1:0] RATE_ADDR = {slr_pkg::REG_SEL_RATE, 2'b00};
    localparam logic [slr_pkg::PADDR_W-1:0] MODE_ADDR = {slr_pkg::REG_SEL_MODE, 2'b00};

    typedef struct {
        logic [SMP_W-1:0] left;
        logic [SMP_W-1:0] right;
        logic             last;
    } t_out_beat;

    class interp_scoreboard;
        logic [PH_W-1:0]  rate;
        logic             mode;
        logic [SMP_W-1:0] prev_l;
        logic [SMP_W-1:0] prev_r;
        logic [PH_W-1:0]  phase;
        t_out_beat        due_beats[$];
        int               errors;

        function new();
            rate   = 20'd65536;
            mode   = slr_pkg::MODE_STEREO;
            prev_l = '0;
            prev_r = '0;
            phase  = '0;
            errors = 0;
        endfunction

        function longint lerp(longint a, longint b, longint ph);
            // arithmetic shift floors the product onto the sample grid
            return a + (((b - a) * ph) >>> FRAC_W);
        endfunction

        // work out every beat an accepted frame gives and queue them
        function void take_frame(logic [SMP_W-1:0] in_l, logic [SMP_W-1:0] in_r);
            longint    xl, xr, pl, pr, ph, l, r;
            int        n;
            t_out_beat b;
            xl = longint'($signed(in_l));
            xr = longint'($signed(in_r));
            pl = longint'($signed(prev_l));
            pr = longint'($signed(prev_r));
            ph = longint'(phase);
            n  = 0;
            while (ph <= PH_ONE && n < slr_pkg::MAX_RESULTS) begin
                l = lerp(pl, xl, ph);
                r = lerp(pr, xr, ph);
                if (mode == slr_pkg::MODE_MONO) begin
                    l = (l + r) >>> 1;
                    r = l;
                end
                b.left  = l[SMP_W-1:0];
                b.right = r[SMP_W-1:0];
                b.last  = 1'b0;
                due_beats.push_back(b);
                ph = ph + longint'(rate);
                n++;
            end
            if (n > 0)
                due_beats[due_beats.size()-1].last = 1'b1;
            // wrap saturates at zero when the cap stopped the run early
            ph     = (ph >= PH_ONE) ? ph - PH_ONE : 64'd0;
            phase  = ph[PH_W-1:0];
            prev_l = in_l;
            prev_r = in_r;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_beat(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r, logic last);
            t_out_beat want;
            if (due_beats.size() == 0) begin
                report($sformatf("unexpected beat left %h right %h last %b", l, r, last));
                return;
            end
            want = due_beats.pop_front();
            if (l !== want.left)
                report($sformatf("left %h, wanted %h", l, want.left));
            if (r !== want.right)
                report($sformatf("right %h, wanted %h", r, want.right));
            if (last !== want.last)
                report($sformatf("last %b, wanted %b", last, want.last));
        endtask
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    // in_left [23:0], in_right [47:24]
    logic [DATA_W-1:0]            s_axis_tdata = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // out_left [23:0], out_right [47:24]
    logic [DATA_W-1:0]            m_axis_tdata;
    logic                         m_axis_tlast;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [slr_pkg::PADDR_W-1:0]  paddr = '0;
    logic [slr_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [slr_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    interp_scoreboard sb = new();
    int               frames_in = 0;
    int               beats_out = 0;
    int               quiet_cyc = 0;
    logic [SMP_W-1:0] last_l = '0;
    logic [SMP_W-1:0] last_r = '0;

    stereo_linear_resampler_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic apb_write(input logic [slr_pkg::PADDR_W-1:0] addr,
                             input logic [slr_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == RATE_ADDR)
            sb.rate = data[PH_W-1:0];
        else
            sb.mode = data[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait out every expected beat, let zero-result frames finish, then set up
    task automatic settle_and_configure(input logic [PH_W-1:0] rate, input logic mode);
        // stop offering the last frame again while the block drains
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        apb_write(RATE_ADDR, slr_pkg::PDATA_W'(rate));
        apb_write(MODE_ADDR, slr_pkg::PDATA_W'(mode));
    endtask

    task automatic send_frame(input logic [SMP_W-1:0] l, input logic [SMP_W-1:0] r);
        int gap;
        gap = 0;
        if (frames_in < 200 || frames_in >= 280)
            while ($urandom_range(99) < 35)
                gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'({r, l});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_frame(l, r);
        frames_in++;
        last_l = l;
        last_r = r;
    endtask

    function automatic logic [SMP_W-1:0] pick_sample(input logic [SMP_W-1:0] near);
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(4))
                0: return 24'h7FFFFF;
                1: return 24'h800000;
                2: return 24'h000000;
                3: return 24'hFFFFFF;
                default: return 24'h000001;
            endcase
        end else if (sel < 40) begin
            // small step from the last frame, fine detail of the interpolation
            return near + SMP_W'(int'($urandom_range(512)) - 256);
        end
        return SMP_W'($urandom);
    endfunction

    function automatic logic [PH_W-1:0] pick_rate();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) begin
            case ($urandom_range(4))
                0: return 20'd0;
                1: return 20'd8192;
                2: return 20'd65536;
                3: return 20'd524288;
                default: return 20'hFFFFF;
            endcase
        end else if (sel < 20) begin
            return PH_W'($urandom_range(8191));
        end else if (sel < 30) begin
            return PH_W'($urandom_range(20'hFFFFF, 524289));
        end
        return PH_W'($urandom_range(524288, 8192));
    endfunction

    // result side: random back-pressure, one long hold, one calm stretch
    initial begin : sink
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && beats_out >= 100) begin
                held      = 1'b1;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (beats_out >= 250 && beats_out < 400) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 35);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_out++;
                sb.check_beat(m_axis_tdata[SMP_W-1:0], m_axis_tdata[2*SMP_W-1:SMP_W],
                              m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pready)) begin
                quiet_cyc = 0;
            end else begin
                quiet_cyc++;
            end
            if (quiet_cyc >= QUIET_MAX) begin
                $display("stereo_linear_resampler_unit_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // half rate, stereo: field extremes
        settle_and_configure(20'd32768, slr_pkg::MODE_STEREO);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        send_frame(24'h800000, 24'h800000);
        send_frame(24'h555555, 24'hAAAAAA);

        // zero rate, mono: result cap and phase saturating at zero
        settle_and_configure(20'd0, slr_pkg::MODE_MONO);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        send_frame(24'h800000, 24'h800000);
        send_frame(24'h7FFFFF, 24'h800000);

        // widest rate: phase left above one, frames giving nothing
        settle_and_configure(20'hFFFFF, slr_pkg::MODE_STEREO);
        send_frame(24'h123456, 24'hFEDCBA);
        send_frame(24'hFFFFFF, 24'h000001);
        send_frame(24'h400000, 24'hC00000);
        send_frame(24'h000001, 24'hFFFFFF);

        // top of the usual range, mono
        settle_and_configure(20'd524288, slr_pkg::MODE_MONO);
        send_frame(24'hAAAAAA, 24'h555555);
        send_frame(24'h7FFFFF, 24'h000000);
        send_frame(24'h800000, 24'hFFFFFF);

        // bottom of the usual range, stereo: nine results meeting the cap
        settle_and_configure(20'd8192, slr_pkg::MODE_STEREO);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h0F0F0F, 24'hF0F0F0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            settle_and_configure(pick_rate(), logic'($urandom_range(1)));
            for (int k = 0; k < FRAMES_PER_PH; k++)
                send_frame(pick_sample(last_l), pick_sample(last_r));
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (sb.errors == 0)
            $display("stereo_linear_resampler_unit_tb: done, clean");
        else
            $display("stereo_linear_resampler_unit_tb: done, errors");
        $finish;
    end

endmodule
